// File: design/lpc_pkg.sv
// Shared types, constants and AES helper functions for the payload cipher.
`timescale 1ns / 1ps
package lpc_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam int QUEUE_DEPTH = 4;
	localparam int AES_ROUNDS = 10;
	localparam int ROUND_W = $clog2(AES_ROUNDS + 1);

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW = 2'd1;

	localparam logic [7:0] A_TAG = 8'h01;
	localparam logic [7:0] A_PAD = 8'h00;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        first_of_frame;
		logic        direction;
		logic [31:0] device_address;
		logic [31:0] frame_counter;
		logic        last_of_frame;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       last_out;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic             fresh;
		logic [POS_W-1:0] pos;
		logic             dir;
		logic [31:0]      addr;
		logic [31:0]      fcnt;
		logic [7:0]       blk_num;
	} job_t;

	typedef struct packed {
		logic busy;
		logic done;
	} aes_stat_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] get_b(input logic [127:0] v, input int i);
		return v[127 - 8*i -: 8];
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = rk[127:96];
		w1 = rk[95:64];
		w2 = rk[63:32];
		w3 = rk[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] round_fn(input logic [127:0] s, input logic final_rnd);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				t[k + 4*c] = SBOX[get_b(s, k + 4*((c + k) & 3))];
			end
		end
		if (!final_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c];
				a1 = t[4*c + 1];
				a2 = t[4*c + 2];
				a3 = t[4*c + 3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c] = a0 ^ all ^ xt(a0 ^ a1);
				t[4*c + 1] = a1 ^ all ^ xt(a1 ^ a2);
				t[4*c + 2] = a2 ^ all ^ xt(a2 ^ a3);
				t[4*c + 3] = a3 ^ all ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8*i -: 8] = t[i];
		end
		return r;
	endfunction

endpackage

// File: design/lpc_front.sv
// Front end: accepts payload beats, tracks frame position and queues classified jobs.
`timescale 1ns / 1ps
module lpc_front import lpc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_beat_t in_data,
	input  logic     push_ok,
	output logic     push,
	output job_t     job
);

	logic [POS_W-1:0] pos_q, pos_e, pos_n;
	logic [7:0]       idx_q, idx_e;
	logic             dir_q, dir_e;
	logic [31:0]      addr_q, addr_e, ctr_q, ctr_e;

	assign push = in_valid && push_ok;

	always_comb begin
		if (in_data.first_of_frame) begin
			pos_e = '0;
			idx_e = '0;
			dir_e = in_data.direction;
			addr_e = in_data.device_address;
			ctr_e = in_data.frame_counter;
		end else begin
			pos_e = pos_q;
			idx_e = idx_q;
			dir_e = dir_q;
			addr_e = addr_q;
			ctr_e = ctr_q;
		end
		pos_n = pos_e + 1'b1;
		job.data = in_data.payload_byte;
		job.last = in_data.last_of_frame;
		job.fresh = (pos_e == '0);
		job.pos = pos_e;
		job.dir = dir_e;
		job.addr = addr_e;
		job.fcnt = ctr_e;
		job.blk_num = idx_e + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			idx_q <= '0;
			dir_q <= 1'b0;
			addr_q <= '0;
			ctr_q <= '0;
		end else if (push) begin
			dir_q <= dir_e;
			addr_q <= addr_e;
			ctr_q <= ctr_e;
			if (in_data.last_of_frame) begin
				pos_q <= '0;
				idx_q <= '0;
			end else begin
				pos_q <= pos_n;
				idx_q <= (pos_n == '0) ? idx_e + 8'd1 : idx_e;
			end
		end
	end

endmodule

// File: design/lpc_queue.sv
// Short job queue between the front end and the keystream back end.
`timescale 1ns / 1ps
module lpc_queue import lpc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic not_full,
	input  logic pop,
	output logic not_empty,
	output job_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_full = (cnt_q != CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/lpc_aes.sv
// Iterative AES-128 encryption, one round per cycle with on-the-fly key expansion.
`timescale 1ns / 1ps
module lpc_aes import lpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] block,
	input  logic [127:0] key,
	output aes_stat_t    stat,
	output logic [127:0] result
);

	logic [127:0]       st_q, rk_q, rk_n;
	logic [ROUND_W-1:0] round_q;
	logic               busy_q, done_q;

	assign rk_n = key_next(rk_q, rcon(round_q));
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = st_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			st_q <= block ^ key;
			rk_q <= key;
		end else if (busy_q) begin
			st_q <= round_fn(st_q, round_q == ROUND_W'(AES_ROUNDS)) ^ rk_n;
			rk_q <= rk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			round_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				round_q <= ROUND_W'(1);
			end else if (busy_q) begin
				round_q <= round_q + 1'b1;
				if (round_q == ROUND_W'(AES_ROUNDS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: design/lpc_back.sv
// Back end: fetches keystream blocks, XORs queued bytes and holds the output beat.
`timescale 1ns / 1ps
module lpc_back import lpc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [127:0] key,
	input  logic         head_valid,
	input  job_t         head,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output out_beat_t    out_data
);

	logic [127:0] ks_q, a_blk, aes_res;
	logic         ks_ok_q, out_valid_q, can_out, aes_start;
	out_beat_t    out_q;
	aes_stat_t    aes_st;
	logic [7:0]   ks_byte;

	assign a_blk = {A_TAG, 32'h0, 7'h0, head.dir,
		head.addr[7:0], head.addr[15:8], head.addr[23:16], head.addr[31:24],
		head.fcnt[7:0], head.fcnt[15:8], head.fcnt[23:16], head.fcnt[31:24],
		A_PAD, head.blk_num};

	assign aes_start = head_valid && head.fresh && !ks_ok_q && !aes_st.busy && !aes_st.done;
	assign can_out = !out_valid_q || !out_stall;
	assign pop = head_valid && (!head.fresh || ks_ok_q) && can_out;
	assign ks_byte = ks_q[127 - 8*head.pos -: 8];
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	lpc_aes u_aes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (aes_start),
		.block  (a_blk),
		.key    (key),
		.stat   (aes_st),
		.result (aes_res)
	);

	always_ff @(posedge clk) begin
		if (aes_st.done) begin
			ks_q <= aes_res;
		end
		if (pop) begin
			out_q.cipher_byte <= head.data ^ ks_byte;
			out_q.last_out <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (aes_st.done) begin
				ks_ok_q <= 1'b1;
			end else if (pop && head.fresh) begin
				ks_ok_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/lorawan_payload_cipher_core.sv
// LoRaWAN payload cipher: AES-128 counter-mode keystream XOR, one byte per beat.
// Input channel (in_valid/in_stall/in_data): one payload byte per beat with frame
// marks and header fields; header is latched on a first-of-frame beat.
// Output channel (out_valid/out_stall/out_data): one cipher byte per input beat,
// in order, with the last-of-frame mark copied.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes key
// bytes 0..7, index 1 key bytes 8..15; other indexes are dropped. Always ready.
// A byte that opens a 16-byte block waits at the queue head for the iterative
// AES unit; other bytes pass through the queue to the registered output beat.
// The byte rate is set by the ten AES rounds, run one per cycle for a block
// once its first byte is at the queue head; the queue keeps accepting beats.
// Reset clears frame position, block index, held header, key and all valid
// flags. A stalled output beat holds; the queue fills and in_stall rises when
// it is full.
`timescale 1ns / 1ps
module lorawan_payload_cipher_core import lpc_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_beat_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_high_q, key_low_q;
	logic        push, push_ok, pop, head_valid;
	job_t        job, head;

	assign cfg_ready = 1'b1;
	assign in_stall = !push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW: key_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lpc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_data (in_data),
		.push_ok (push_ok),
		.push    (push),
		.job     (job)
	);

	lpc_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.not_full (push_ok),
		.pop      (pop),
		.not_empty(head_valid),
		.head     (head)
	);

	lpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       ({key_high_q, key_low_q}),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: verif/lpc_checker.sv
// Checker: predicts payload cipher output beats and compares them with the block.
`timescale 1ns / 1ps
module lpc_checker import lpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_beat_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_beat_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [63:0] key_hi, key_lo;
	logic [7:0] ks [16];
	logic [7:0] blk_idx;
	logic [3:0] pos;
	logic hdr_dir;
	logic [31:0] hdr_addr, hdr_fcnt;
	out_beat_t cipher_q[$];

	assign pending = cipher_q.size();

	function automatic logic [7:0] gmul2(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	task automatic aes_encrypt(inout logic [7:0] b [16]);
		logic [7:0] rk [176];
		logic [7:0] t [16];
		logic [7:0] w0, w1, w2, w3, s, a0, a1, a2, a3, x;
		logic [7:0] rc;
		for (int i = 0; i < 8; i++) begin
			rk[i] = key_hi[63 - 8*i -: 8];
			rk[8 + i] = key_lo[63 - 8*i -: 8];
		end
		rc = 8'h01;
		for (int i = 16; i < 176; i += 4) begin
			w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
			if ((i & 15) == 0) begin
				s = w0;
				w0 = SBOX[w1] ^ rc;
				w1 = SBOX[w2];
				w2 = SBOX[w3];
				w3 = SBOX[s];
				rc = gmul2(rc);
			end
			rk[i] = rk[i-16] ^ w0;
			rk[i+1] = rk[i-15] ^ w1;
			rk[i+2] = rk[i-14] ^ w2;
			rk[i+3] = rk[i-13] ^ w3;
		end
		for (int i = 0; i < 16; i++) b[i] ^= rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int k = 0; k < 4; k++)
					t[k + 4*c] = SBOX[b[k + 4*((c + k) & 3)]];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					x = a0 ^ a1 ^ a2 ^ a3;
					t[4*c] = a0 ^ x ^ gmul2(a0 ^ a1);
					t[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
					t[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
					t[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
				end
			end
			for (int i = 0; i < 16; i++) b[i] = t[i] ^ rk[16*r + i];
		end
	endtask

	task automatic predict_cipher(input in_beat_t d);
		logic [7:0] a [16];
		out_beat_t e;
		if (d.first_of_frame) begin
			hdr_dir = d.direction;
			hdr_addr = d.device_address;
			hdr_fcnt = d.frame_counter;
			blk_idx = '0;
			pos = '0;
		end
		if (pos == 0) begin
			a[0] = A_TAG;
			for (int i = 1; i < 5; i++) a[i] = A_PAD;
			a[5] = {7'd0, hdr_dir};
			for (int i = 0; i < 4; i++) begin
				a[6 + i] = hdr_addr[8*i +: 8];
				a[10 + i] = hdr_fcnt[8*i +: 8];
			end
			a[14] = A_PAD;
			a[15] = blk_idx + 8'd1;
			aes_encrypt(a);
			ks = a;
		end
		e.cipher_byte = d.payload_byte ^ ks[pos];
		e.last_out = d.last_of_frame;
		cipher_q.push_back(e);
		pos = pos + 4'd1;
		if (pos == 0) blk_idx = blk_idx + 8'd1;
		if (d.last_of_frame) begin
			pos = '0;
			blk_idx = '0;
		end
	endtask

	task automatic report(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		key_hi = '0; key_lo = '0;
		blk_idx = '0; pos = '0;
		hdr_dir = 1'b0; hdr_addr = '0; hdr_fcnt = '0;
	end

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_KEY_HIGH) key_hi = cfg_data;
				else if (cfg_index == REG_KEY_LOW) key_lo = cfg_data;
			end
			if (in_valid && !in_stall) predict_cipher(in_data);
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					report("output beat with nothing expected");
				end else begin
					e = cipher_q.pop_front();
					if (out_data.cipher_byte !== e.cipher_byte)
						report($sformatf("cipher_byte got %h exp %h",
							out_data.cipher_byte, e.cipher_byte));
					if (out_data.last_out !== e.last_out)
						report($sformatf("last_out got %b exp %b",
							out_data.last_out, e.last_out));
				end
			end
		end
	end

endmodule

// File: verif/tb_top.sv
// Top of the payload cipher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import lpc_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	in_beat_t in_data;
	out_beat_t out_data;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;
	int fail_count, pending, idle_cycles;
	bit rx_calm;

	lorawan_payload_cipher_core i_dut (.*);
	lpc_checker i_chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("[lorawan_payload_cipher_core] ERROR");
		$finish;
	end

	// receiver: random stall stretches, with calm phases
	initial begin
		int w;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_calm) begin
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				w = $urandom_range(0, 7);
				if (w > 0) begin
					out_stall <= 1'b1;
					repeat (w) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic write_key(input logic [1:0] idx, input logic [63:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input bit first, input bit dir,
			input logic [31:0] addr, input logic [31:0] fcnt, input bit last,
			input bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w - 1) @(negedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{payload_byte: b, first_of_frame: first, direction: dir,
			device_address: addr, frame_counter: fcnt, last_of_frame: last};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_frame(input int len, input bit gaps);
		bit dir;
		logic [31:0] addr, fcnt;
		dir = 1'($urandom_range(0, 1));
		addr = $urandom;
		fcnt = $urandom;
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), i == 0, dir, addr, fcnt, i == len - 1,
				gaps);
	endtask

	task automatic release_input;
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		int n, len;
		bit gaps;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		rx_calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero key, no first mark after reset, then extremes
		send_byte(8'h00, 1'b0, 1'b1, '1, '1, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0, '0, '0, 1'b1, 1'b0);
		send_byte(8'h5a, 1'b1, 1'b1, '1, '1, 1'b1, 1'b0);
		send_byte(8'ha5, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
		for (int i = 0; i < 17; i++)
			send_byte(i[7:0], 1'b0, 1'b1, '1, '1, i == 16, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0, 32'h1, 32'h1, 1'b1, 1'b1);
		release_input();
		drain();

		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		write_key(2'd2, 64'h1234);
		write_key(2'd3, 64'h5678);
		send_frame(20, 1'b0);
		send_frame(1, 1'b1);
		release_input();
		drain();

		// one long frame spans several blocks
		write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
		write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
		rx_calm = 1'b1;
		send_frame(16 * 4 + 3, 1'b0);
		release_input();
		drain();
		rx_calm = 1'b0;

		n = 0;
		while (n < 900) begin
			if ((n % 250) == 0) begin
				release_input();
				drain();
				write_key(REG_KEY_HIGH, {$urandom, $urandom});
				write_key(REG_KEY_LOW, {$urandom, $urandom});
				rx_calm = ($urandom_range(0, 3) == 0);
			end
			gaps = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) == 0) begin
				len = 1;
				send_byte(8'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom,
					1'($urandom), gaps);
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
				send_frame(len, gaps);
			end
			n += len;
		end
		release_input();
		rx_calm = 1'b0;
		drain();
		if (fail_count == 0)
			$display("[lorawan_payload_cipher_core] OK");
		else
			$display("[lorawan_payload_cipher_core] ERROR");
		$finish;
	end

endmodule

// File: filelist.f
design/lpc_pkg.sv
design/lpc_front.sv
design/lpc_queue.sv
design/lpc_aes.sv
design/lpc_back.sv
design/lorawan_payload_cipher_core.sv
verif/lpc_checker.sv
verif/tb_top.sv
